// ===== rtl/vvfe_pkg.sv =====
// Shared types, codes and constants of the voxel visible-face extractor.
`timescale 1ns / 1ps
`default_nettype none

package vvfe_pkg;

	// Default grid storage extent per axis
	localparam int MAX_DIM_DEF = 32;

	localparam int COORD_W = 5;
	localparam int SIZE_W  = 6;
	localparam int CELL_W  = 9;
	localparam int COLOR_W = 8;
	localparam int COUNT_W = 24;
	localparam int DIR_W   = 3;
	localparam int KIND_W  = 2;

	// Cell pattern that marks an empty voxel
	localparam logic [CELL_W-1:0] EMPTY_CELL = '1;

	// Vertices taken by one quad face
	localparam logic [COUNT_W:0] VERTS_PER_FACE = (COUNT_W + 1)'(4);

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	// Face direction of an invalid record
	localparam logic [DIR_W-1:0] DIR_POS_Y = 3'd0;

	// Axis codes, taken from the upper bits of a direction
	localparam logic [1:0] AXIS_Y = 2'd0;
	localparam logic [1:0] AXIS_Z = 2'd1;
	localparam logic [1:0] AXIS_X = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic [COORD_W-1:0]       pos_x;
		logic [COORD_W-1:0]       pos_y;
		logic [COORD_W-1:0]       pos_z;
		logic signed [CELL_W-1:0] cell_color;
	} in_item_t;

	typedef struct packed {
		logic [SIZE_W-1:0] x;
		logic [SIZE_W-1:0] y;
		logic [SIZE_W-1:0] z;
	} cfg_sizes_t;

	typedef struct packed {
		logic               face_valid;
		logic [DIR_W-1:0]   face_dir;
		logic [COORD_W-1:0] face_x;
		logic [COORD_W-1:0] face_y;
		logic [COORD_W-1:0] face_z;
		logic [COLOR_W-1:0] face_color;
		logic [COUNT_W-1:0] vertex_base;
		logic               vertex_overflow;
		logic               last;
	} face_rec_t;

endpackage

`default_nettype wire

// ===== rtl/vvfe_grid_mem.sv =====
// Single-port voxel grid memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module vvfe_grid_mem
	import vvfe_pkg::*;
#(
	parameter int ADDR_W = 15
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [CELL_W-1:0] wdata,
	output logic      [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [2**ADDR_W];

	// Write or read one cell per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vvfe_nbr_unit.sv =====
// Shared neighbour unit: steps one axis by one cell and checks it against the grid size.
`timescale 1ns / 1ps
`default_nettype none

module vvfe_nbr_unit
	import vvfe_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic [COORD_W-1:0]        x,
	input  wire logic [COORD_W-1:0]        y,
	input  wire logic [COORD_W-1:0]        z,
	input  wire logic [DIR_W-1:0]          dir,
	input  wire logic [SIZE_W-1:0]         eff_x,
	input  wire logic [SIZE_W-1:0]         eff_y,
	input  wire logic [SIZE_W-1:0]         eff_z,
	output logic      [3*$clog2(MAX_DIM)-1:0] addr,
	output logic                           inb
);

	localparam int AW = $clog2(MAX_DIM);

	logic [COORD_W-1:0] c;
	logic [SIZE_W-1:0]  e;
	logic [SIZE_W-1:0]  n;
	logic [SIZE_W-1:0]  nx, ny, nz;
	logic               under;

	// Pick the axis the direction moves along
	always_comb begin
		unique case (dir[2:1])
			AXIS_Y: begin
				c = y;
				e = eff_y;
			end
			AXIS_Z: begin
				c = z;
				e = eff_z;
			end
			default: begin
				c = x;
				e = eff_x;
			end
		endcase
	end

	// Step by one cell and test the bound
	assign n     = dir[0] ? (SIZE_W'(c) - SIZE_W'(1)) : (SIZE_W'(c) + SIZE_W'(1));
	assign under = dir[0] && (c == '0);
	assign inb   = !under && (n < e);

	// Replace the moved coordinate
	always_comb begin
		nx = SIZE_W'(x);
		ny = SIZE_W'(y);
		nz = SIZE_W'(z);
		unique case (dir[2:1])
			AXIS_Y:  ny = n;
			AXIS_Z:  nz = n;
			default: nx = n;
		endcase
	end

	assign addr = {AW'(nz), AW'(ny), AW'(nx)};

endmodule

`default_nettype wire

// ===== rtl/vvfe_seq.sv =====
// Item sequencer: writes cells, walks a query over centre and six neighbours, emits face records.
`timescale 1ns / 1ps
`default_nettype none

module vvfe_seq
	import vvfe_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire in_item_t                      in_item,
	input  wire cfg_sizes_t                    sizes,
	output logic                               mem_we,
	output logic      [3*$clog2(MAX_DIM)-1:0]  mem_addr,
	output logic      [CELL_W-1:0]             mem_wdata,
	input  wire logic [CELL_W-1:0]             mem_rdata,
	output logic                               rec_valid,
	input  wire logic                          rec_ready,
	output face_rec_t                          rec
);

	localparam int AW  = $clog2(MAX_DIM);
	localparam int GAW = 3 * AW;
	localparam logic [8:0] MAXD = 9'(MAX_DIM);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]         state_q;
	logic [2:0]         step_q;
	logic [COORD_W-1:0] x_q, y_q, z_q;
	logic [COLOR_W-1:0] color_q;
	logic [5:0]         mask_q;
	logic               inv_q;
	logic               inb_q;
	logic [COUNT_W-1:0] count_q;
	logic               ovf_q;

	logic [SIZE_W-1:0]  eff_x, eff_y, eff_z;
	logic               in_fire, rec_fire;
	logic               ctr_inside, wr_in_range;
	logic [GAW-1:0]     in_addr, nb_addr;
	logic               nb_inb, nb_vis;
	logic [DIR_W-1:0]   nb_dir, ev_dir, lo_dir;
	logic [5:0]         mask_nx, lo_bit, mask_rest;
	logic [COUNT_W:0]   sum;

	// Effective extents, capped at the storage size
	assign eff_x = ({3'd0, sizes.x} > MAXD) ? SIZE_W'(MAX_DIM) : sizes.x;
	assign eff_y = ({3'd0, sizes.y} > MAXD) ? SIZE_W'(MAX_DIM) : sizes.y;
	assign eff_z = ({3'd0, sizes.z} > MAXD) ? SIZE_W'(MAX_DIM) : sizes.z;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign rec_fire = rec_valid && rec_ready;

	assign ctr_inside = (SIZE_W'(in_item.pos_x) < eff_x) && (SIZE_W'(in_item.pos_y) < eff_y) &&
		(SIZE_W'(in_item.pos_z) < eff_z);
	assign wr_in_range = (9'(in_item.pos_x) < MAXD) && (9'(in_item.pos_y) < MAXD) &&
		(9'(in_item.pos_z) < MAXD);
	assign in_addr = {AW'(in_item.pos_z), AW'(in_item.pos_y), AW'(in_item.pos_x)};

	// Neighbour of the step being issued
	assign nb_dir = step_q - 3'd1;

	vvfe_nbr_unit #(
		.MAX_DIM (MAX_DIM)
	) u_nbr (
		.x     (x_q),
		.y     (y_q),
		.z     (z_q),
		.dir   (nb_dir),
		.eff_x (eff_x),
		.eff_y (eff_y),
		.eff_z (eff_z),
		.addr  (nb_addr),
		.inb   (nb_inb)
	);

	// Memory port: input address while idle, neighbour address while reading
	assign mem_we    = in_fire && (in_item.kind == KIND_WRITE) && wr_in_range;
	assign mem_addr  = (state_q == ST_IDLE) ? in_addr : nb_addr;
	assign mem_wdata = $unsigned(in_item.cell_color);

	// Visibility of the neighbour whose cell has just come back
	assign ev_dir = step_q - 3'd2;
	assign nb_vis = !inb_q || (mem_rdata == EMPTY_CELL);

	always_comb begin
		mask_nx = mask_q;
		if (step_q >= 3'd2 && nb_vis) begin
			mask_nx[ev_dir] = 1'b1;
		end
	end

	// Lowest pending face
	always_comb begin
		lo_dir = '0;
		for (int i = 5; i >= 0; i--) begin
			if (mask_q[i]) begin
				lo_dir = DIR_W'(i);
			end
		end
	end
	assign lo_bit    = 6'd1 << lo_dir;
	assign mask_rest = mask_q & ~lo_bit;

	// Vertex allocation for the face on offer
	assign sum = {1'b0, count_q} + VERTS_PER_FACE;

	// Record on offer
	assign rec_valid = (state_q == ST_EMIT);
	always_comb begin
		rec.face_x     = x_q;
		rec.face_y     = y_q;
		rec.face_z     = z_q;
		rec.face_color = color_q;
		rec.vertex_base = count_q;
		if (inv_q) begin
			rec.face_valid      = 1'b0;
			rec.face_dir        = DIR_POS_Y;
			rec.vertex_overflow = ovf_q;
			rec.last            = 1'b1;
		end else begin
			rec.face_valid      = 1'b1;
			rec.face_dir        = lo_dir;
			rec.vertex_overflow = ovf_q | sum[COUNT_W];
			rec.last            = (mask_rest == '0);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			color_q <= '0;
			mask_q  <= '0;
			inv_q   <= 1'b0;
			inb_q   <= 1'b0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_item.kind == KIND_QUERY) begin
							// Centre cell read goes out this cycle
							x_q    <= in_item.pos_x;
							y_q    <= in_item.pos_y;
							z_q    <= in_item.pos_z;
							step_q <= 3'd1;
							mask_q <= '0;
							if (ctr_inside) begin
								inv_q   <= 1'b0;
								state_q <= ST_READ;
							end else begin
								inv_q   <= 1'b1;
								color_q <= '0;
								state_q <= ST_EMIT;
							end
						end else if (in_item.kind == KIND_RESTART) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				ST_READ: begin
					// Issue the next neighbour, judge the one returned
					step_q <= step_q + 3'd1;
					inb_q  <= nb_inb;
					if (step_q == 3'd1) begin
						if (mem_rdata == EMPTY_CELL) begin
							inv_q   <= 1'b1;
							color_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							color_q <= mem_rdata[COLOR_W-1:0];
						end
					end else begin
						mask_q <= mask_nx;
						if (step_q == 3'd7) begin
							inv_q   <= (mask_nx == '0);
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (rec_fire) begin
						if (inv_q) begin
							state_q <= ST_IDLE;
						end else begin
							count_q <= sum[COUNT_W-1:0];
							ovf_q   <= ovf_q | sum[COUNT_W];
							mask_q  <= mask_rest;
							if (mask_rest == '0) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/voxel_visible_face_extract_top.sv =====
// Top level of the voxel visible-face extractor: ports, size registers, output register.
//
// Input channel s_axis: one item per handshake. tuser carries the kind (write a cell,
// query a voxel, restart the vertex counter); tdata carries the coordinates and the colour.
// Output channel m_axis: face records. tuser is the valid-face flag, tlast marks the final
// record of a query. A query yields one to six records; writes and restarts yield none.
// Configuration: cfg_we/cfg_addr/cfg_wdata set size_x, size_y, size_z, to be written while
// idle by the user; the block itself does not enforce this. Sequence: a write or restart
// leaves the sequencer idle. A query of a filled voxel reads the centre cell in the accept
// cycle, six neighbours and one drain read through the single grid memory port and the one
// neighbour unit, then offers one record per cycle unless m_axis stalls. Records reach
// m_axis through the output register; out-of-size and empty voxels give an invalid record.
// Stalls: with m_axis_tready low, the output register holds its record and the sequencer
// waits; s_axis_tready stays low until the query's last record is handed over.
// Reset: clears the vertex counter, the overflow flag and the control state, and sets all
// sizes to 32. The grid contents are not cleared; cells read before writing are undefined.
`timescale 1ns / 1ps
`default_nettype none

module voxel_visible_face_extract_top
	import vvfe_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // pos_x, pos_y, pos_z, cell_color
	input  wire logic [1:0]  s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// face_dir, face_x, face_y, face_z, face_color, vertex_base, vertex_overflow, zero pad
	output logic      [55:0] m_axis_tdata,
	output logic      [0:0]  m_axis_tuser,  // face_valid
	output logic             m_axis_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [5:0]  cfg_wdata
);

	localparam int GAW = 3 * $clog2(MAX_DIM);

	in_item_t          in_item;
	cfg_sizes_t        sizes_q;
	logic              mem_we;
	logic [GAW-1:0]    mem_addr;
	logic [CELL_W-1:0] mem_wdata, mem_rdata;
	logic              rec_valid, rec_ready;
	face_rec_t         rec;
	logic              m_valid_q;
	face_rec_t         m_rec_q;

	// Unpack the input item
	assign in_item.kind       = s_axis_tuser;
	assign in_item.pos_x      = s_axis_tdata[4:0];
	assign in_item.pos_y      = s_axis_tdata[9:5];
	assign in_item.pos_z      = s_axis_tdata[14:10];
	assign in_item.cell_color = $signed(s_axis_tdata[23:15]);

	// Size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sizes_q.x <= 6'd32;
			sizes_q.y <= 6'd32;
			sizes_q.z <= 6'd32;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SIZE_X: sizes_q.x <= cfg_wdata;
				REG_SIZE_Y: sizes_q.y <= cfg_wdata;
				REG_SIZE_Z: sizes_q.z <= cfg_wdata;
				default: ;
			endcase
		end
	end

	vvfe_grid_mem #(
		.ADDR_W (GAW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	vvfe_seq #(
		.MAX_DIM (MAX_DIM)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.sizes     (sizes_q),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec)
	);

	// Output register: load whenever empty or being drained
	assign rec_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (rec_ready) begin
			m_valid_q <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_ready && rec_valid) begin
			m_rec_q <= rec;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'd0, m_rec_q.vertex_overflow, m_rec_q.vertex_base,
		m_rec_q.face_color, m_rec_q.face_z, m_rec_q.face_y, m_rec_q.face_x, m_rec_q.face_dir};
	assign m_axis_tuser  = m_rec_q.face_valid;
	assign m_axis_tlast  = m_rec_q.last;

endmodule

`default_nettype wire
